### rtl/core/three_color_brain_automaton_step_unit_defines.svh
// Assertion macros shared by the step unit; clock aclk, reset aresetn.
`ifndef THREE_COLOR_BRAIN_AUTOMATON_STEP_UNIT_DEFINES_SVH
`define THREE_COLOR_BRAIN_AUTOMATON_STEP_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BBS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bbs check failed");

// Next-cycle implication.
`define BBS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bbs check failed");

`endif

### rtl/core/bbs_pkg.sv
package bbs_pkg;

    localparam int BOARD_ROWS = 64;
    localparam int BOARD_COLS = 64;

    localparam int ROW_W     = $clog2(BOARD_ROWS);
    localparam int COL_W     = $clog2(BOARD_COLS);
    localparam int MEM_AW    = 1 + ROW_W + COL_W;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    // each streamed line carries one wrapped column on either side
    localparam int LINE_LEN  = BOARD_COLS + 2;
    localparam int CHAIN_LEN = 2 * LINE_LEN + 3;
    localparam int SR_W      = $clog2(BOARD_ROWS + 2);
    localparam int SC_W      = $clog2(BOARD_COLS + 2);

    localparam int NBR_COUNT   = 8;
    localparam int CNT_W       = $clog2(NBR_COUNT + 1);
    localparam int BIRTH_COUNT = 4;
    localparam int COLOR_MIN   = 2;

    typedef logic [ROW_W-1:0]  row_idx_t;
    typedef logic [COL_W-1:0]  col_idx_t;
    typedef logic [MEM_AW-1:0] mem_addr_t;
    typedef logic [SR_W-1:0]   sr_t;
    typedef logic [SC_W-1:0]   sc_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef logic [2:0] cell_state_t;
    localparam cell_state_t ST_DEAD        = 3'd0;
    localparam cell_state_t ST_RED_ALIVE   = 3'd1;
    localparam cell_state_t ST_RED_DYING   = 3'd2;
    localparam cell_state_t ST_GREEN_ALIVE = 3'd3;
    localparam cell_state_t ST_GREEN_DYING = 3'd4;
    localparam cell_state_t ST_BLUE_ALIVE  = 3'd5;
    localparam cell_state_t ST_BLUE_DYING  = 3'd6;
    localparam cell_state_t ST_INVALID     = 3'd7;

    typedef logic [1:0] func_t;
    localparam func_t FUNC_WRITE = 2'd0;
    localparam func_t FUNC_READ  = 2'd1;
    localparam func_t FUNC_STEP  = 2'd2;

    typedef struct packed {
        logic red;
        logic green;
        logic blue;
    } alive_t;

    typedef enum logic [2:0] {
        CTL_CLEAR,
        CTL_IDLE,
        CTL_READ,
        CTL_GEN_RUN,
        CTL_GEN_DRAIN
    } ctl_state_t;

endpackage

### rtl/core/bbs_cell.sv
module bbs_cell (
    input  logic                 aclk,
    input  logic                 shift_en,
    input  bbs_pkg::cell_state_t d_in,
    output bbs_pkg::cell_state_t q_out,
    output bbs_pkg::alive_t      alive
);

    bbs_pkg::cell_state_t state_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            state_reg <= d_in;
        end
    end

    assign q_out = state_reg;

    always_comb begin
        alive.red   = (state_reg == bbs_pkg::ST_RED_ALIVE);
        alive.green = (state_reg == bbs_pkg::ST_GREEN_ALIVE);
        alive.blue  = (state_reg == bbs_pkg::ST_BLUE_ALIVE);
    end

endmodule

### rtl/core/bbs_rule.sv
module bbs_rule (
    input  bbs_pkg::cell_state_t self_state,
    input  bbs_pkg::alive_t      nbr [bbs_pkg::NBR_COUNT],
    output bbs_pkg::cell_state_t next_state
);

    bbs_pkg::cnt_t red_cnt;
    bbs_pkg::cnt_t green_cnt;
    bbs_pkg::cnt_t blue_cnt;
    bbs_pkg::cnt_t total_cnt;

    always_comb begin
        red_cnt   = '0;
        green_cnt = '0;
        blue_cnt  = '0;
        for (int i = 0; i < bbs_pkg::NBR_COUNT; i++) begin
            red_cnt   = red_cnt   + bbs_pkg::cnt_t'(nbr[i].red);
            green_cnt = green_cnt + bbs_pkg::cnt_t'(nbr[i].green);
            blue_cnt  = blue_cnt  + bbs_pkg::cnt_t'(nbr[i].blue);
        end
        total_cnt = red_cnt + green_cnt + blue_cnt;
    end

    always_comb begin
        case (self_state)
            bbs_pkg::ST_RED_ALIVE:   next_state = bbs_pkg::ST_RED_DYING;
            bbs_pkg::ST_GREEN_ALIVE: next_state = bbs_pkg::ST_GREEN_DYING;
            bbs_pkg::ST_BLUE_ALIVE:  next_state = bbs_pkg::ST_BLUE_DYING;
            bbs_pkg::ST_DEAD: begin
                next_state = bbs_pkg::ST_DEAD;
                // with four live neighbors, birth takes the first of red, green, blue with two or more
                if (total_cnt == bbs_pkg::cnt_t'(bbs_pkg::BIRTH_COUNT)) begin
                    if (red_cnt >= bbs_pkg::cnt_t'(bbs_pkg::COLOR_MIN)) begin
                        next_state = bbs_pkg::ST_RED_ALIVE;
                    end else if (green_cnt >= bbs_pkg::cnt_t'(bbs_pkg::COLOR_MIN)) begin
                        next_state = bbs_pkg::ST_GREEN_ALIVE;
                    end else if (blue_cnt >= bbs_pkg::cnt_t'(bbs_pkg::COLOR_MIN)) begin
                        next_state = bbs_pkg::ST_BLUE_ALIVE;
                    end
                end
            end
            default: next_state = bbs_pkg::ST_DEAD;
        endcase
    end

endmodule

### rtl/core/three_color_brain_automaton_step_unit.sv
// Seven-state color brain automaton on a wrapped BOARD_ROWS x BOARD_COLS board held in a
// two-bank memory. One beat on s_ writes a cell, reads a cell or advances one generation,
// and each beat gives exactly one beat on m_ (cell_out is zero except for a read). After
// reset the unit clears the board before s_tready rises. A write or an unused code answers
// in the next cycle; a read first passes through the CTL_READ state. For a generation the
// board is streamed one cell per cycle from the memory read port, with a wrapped row and
// column on each side, through a chain of 2*(BOARD_COLS+2)+3 cells that forms the 3x3
// window, and each new cell is written to the other bank, which then becomes the live board.
`include "three_color_brain_automaton_step_unit_defines.svh"

module three_color_brain_automaton_step_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] row, [11:6] col, [14:12] cell_in, [15] zero
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [2:0] cell_out, [7:3] zero
);

    bbs_pkg::ctl_state_t  state_reg, state_next;
    logic                 bank_reg, bank_next;
    logic [bbs_pkg::ROW_W+bbs_pkg::COL_W-1:0] clr_reg, clr_next;
    bbs_pkg::sr_t         sr_reg, sr_next;
    bbs_pkg::sc_t         sc_reg, sc_next;
    logic                 m_valid_reg, m_valid_next;
    bbs_pkg::cell_state_t m_data_reg, m_data_next;

    logic                 vld_d1_reg, vld_d2_reg;
    bbs_pkg::sr_t         sr_d1_reg, sr_d2_reg;
    bbs_pkg::sc_t         sc_d1_reg, sc_d2_reg;
    bbs_pkg::cell_state_t rdata_reg;
    logic                 rd_inside_reg;

    bbs_pkg::func_t       in_func;
    logic [5:0]           in_row;
    logic [5:0]           in_col;
    bbs_pkg::cell_state_t in_cell;
    logic                 in_inside;
    logic                 s_accept;
    logic                 stream_vld;
    logic                 stream_last;
    bbs_pkg::row_idx_t    src_row;
    bbs_pkg::col_idx_t    src_col;
    logic                 win_ok;
    bbs_pkg::cell_state_t rule_next;

    logic                 mem_we;
    bbs_pkg::mem_addr_t   mem_waddr;
    bbs_pkg::mem_addr_t   mem_raddr;
    bbs_pkg::cell_state_t mem_wdata;
    bbs_pkg::cell_state_t board_mem [bbs_pkg::MEM_DEPTH];

    bbs_pkg::cell_state_t chain_d     [bbs_pkg::CHAIN_LEN];
    bbs_pkg::cell_state_t chain_q     [bbs_pkg::CHAIN_LEN];
    bbs_pkg::alive_t      chain_alive [bbs_pkg::CHAIN_LEN];
    bbs_pkg::alive_t      nbr         [bbs_pkg::NBR_COUNT];

    assign in_func  = bbs_pkg::func_t'(s_tuser);
    assign in_row   = s_tdata[5:0];
    assign in_col   = s_tdata[11:6];
    assign in_cell  = s_tdata[14:12];
    assign in_inside = (32'(in_row) < 32'(bbs_pkg::BOARD_ROWS)) &&
                       (32'(in_col) < 32'(bbs_pkg::BOARD_COLS));
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_data_reg};

    // stream position to board cell, with the wrapped row and column on either side
    always_comb begin
        if (sr_reg == '0) begin
            src_row = bbs_pkg::row_idx_t'(bbs_pkg::BOARD_ROWS - 1);
        end else if (sr_reg == bbs_pkg::sr_t'(bbs_pkg::BOARD_ROWS + 1)) begin
            src_row = '0;
        end else begin
            src_row = bbs_pkg::row_idx_t'(sr_reg - bbs_pkg::sr_t'(1));
        end
        if (sc_reg == '0) begin
            src_col = bbs_pkg::col_idx_t'(bbs_pkg::BOARD_COLS - 1);
        end else if (sc_reg == bbs_pkg::sc_t'(bbs_pkg::BOARD_COLS + 1)) begin
            src_col = '0;
        end else begin
            src_col = bbs_pkg::col_idx_t'(sc_reg - bbs_pkg::sc_t'(1));
        end
    end

    assign stream_last = (sr_reg == bbs_pkg::sr_t'(bbs_pkg::BOARD_ROWS + 1)) &&
                         (sc_reg == bbs_pkg::sc_t'(bbs_pkg::BOARD_COLS + 1));

    // window is complete once two lines and two columns have entered the chain
    assign win_ok = vld_d2_reg && (sr_d2_reg >= bbs_pkg::sr_t'(2)) &&
                    (sc_d2_reg >= bbs_pkg::sc_t'(2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bbs_pkg::CTL_CLEAR;
            bank_reg    <= 1'b0;
            clr_reg     <= '0;
            sr_reg      <= '0;
            sc_reg      <= '0;
            m_valid_reg <= 1'b0;
            vld_d1_reg  <= 1'b0;
            vld_d2_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bank_reg    <= bank_next;
            clr_reg     <= clr_next;
            sr_reg      <= sr_next;
            sc_reg      <= sc_next;
            m_valid_reg <= m_valid_next;
            vld_d1_reg  <= stream_vld;
            vld_d2_reg  <= vld_d1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        sr_d1_reg     <= sr_reg;
        sc_d1_reg     <= sc_reg;
        sr_d2_reg     <= sr_d1_reg;
        sc_d2_reg     <= sc_d1_reg;
        rd_inside_reg <= in_inside;
    end

    always_comb begin
        state_next   = state_reg;
        bank_next    = bank_reg;
        clr_next     = clr_reg;
        sr_next      = sr_reg;
        sc_next      = sc_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        s_tready     = 1'b0;
        stream_vld   = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = {bank_reg, bbs_pkg::row_idx_t'(in_row), bbs_pkg::col_idx_t'(in_col)};
        mem_wdata    = bbs_pkg::ST_DEAD;
        mem_raddr    = {bank_reg, bbs_pkg::row_idx_t'(in_row), bbs_pkg::col_idx_t'(in_col)};

        case (state_reg)
            bbs_pkg::CTL_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = {bank_reg, clr_reg};
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = bbs_pkg::CTL_IDLE;
                end
            end
            bbs_pkg::CTL_IDLE: begin
                s_tready = !m_valid_reg || m_tready;
                if (s_accept) begin
                    case (in_func)
                        bbs_pkg::FUNC_WRITE: begin
                            mem_we       = in_inside;
                            mem_wdata    = (in_cell == bbs_pkg::ST_INVALID) ?
                                           bbs_pkg::ST_DEAD : in_cell;
                            m_valid_next = 1'b1;
                            m_data_next  = bbs_pkg::ST_DEAD;
                        end
                        bbs_pkg::FUNC_READ: begin
                            state_next = bbs_pkg::CTL_READ;
                        end
                        bbs_pkg::FUNC_STEP: begin
                            state_next = bbs_pkg::CTL_GEN_RUN;
                            sr_next    = '0;
                            sc_next    = '0;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_data_next  = bbs_pkg::ST_DEAD;
                        end
                    endcase
                end
            end
            bbs_pkg::CTL_READ: begin
                m_valid_next = 1'b1;
                m_data_next  = rd_inside_reg ? rdata_reg : bbs_pkg::ST_DEAD;
                state_next   = bbs_pkg::CTL_IDLE;
            end
            bbs_pkg::CTL_GEN_RUN: begin
                stream_vld = 1'b1;
                mem_raddr  = {bank_reg, src_row, src_col};
                if (sc_reg == bbs_pkg::sc_t'(bbs_pkg::BOARD_COLS + 1)) begin
                    sc_next = '0;
                    sr_next = sr_reg + bbs_pkg::sr_t'(1);
                end else begin
                    sc_next = sc_reg + bbs_pkg::sc_t'(1);
                end
                if (stream_last) begin
                    state_next = bbs_pkg::CTL_GEN_DRAIN;
                end
            end
            bbs_pkg::CTL_GEN_DRAIN: begin
                // flip banks once the last window has been written
                if (!vld_d1_reg && !vld_d2_reg) begin
                    bank_next    = !bank_reg;
                    m_valid_next = 1'b1;
                    m_data_next  = bbs_pkg::ST_DEAD;
                    state_next   = bbs_pkg::CTL_IDLE;
                end
            end
            default: begin
                state_next = bbs_pkg::CTL_IDLE;
            end
        endcase

        if (win_ok) begin
            mem_we    = 1'b1;
            mem_waddr = {!bank_reg,
                         bbs_pkg::row_idx_t'(sr_d2_reg - bbs_pkg::sr_t'(2)),
                         bbs_pkg::col_idx_t'(sc_d2_reg - bbs_pkg::sc_t'(2))};
            mem_wdata = rule_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            board_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= board_mem[mem_raddr];
    end

    assign chain_d[0] = rdata_reg;

    for (genvar k = 0; k < bbs_pkg::CHAIN_LEN; k++) begin : g_chain
        if (k > 0) begin : g_link
            assign chain_d[k] = chain_q[k-1];
        end
        bbs_cell u_cell (
            .aclk     (aclk),
            .shift_en (vld_d1_reg),
            .d_in     (chain_d[k]),
            .q_out    (chain_q[k]),
            .alive    (chain_alive[k])
        );
    end

    // newest line at the chain head, oldest line at the tail
    assign nbr[0] = chain_alive[0];
    assign nbr[1] = chain_alive[1];
    assign nbr[2] = chain_alive[2];
    assign nbr[3] = chain_alive[bbs_pkg::LINE_LEN];
    assign nbr[4] = chain_alive[bbs_pkg::LINE_LEN + 2];
    assign nbr[5] = chain_alive[2 * bbs_pkg::LINE_LEN];
    assign nbr[6] = chain_alive[2 * bbs_pkg::LINE_LEN + 1];
    assign nbr[7] = chain_alive[2 * bbs_pkg::LINE_LEN + 2];

    bbs_rule u_rule (
        .self_state (chain_q[bbs_pkg::LINE_LEN + 1]),
        .nbr        (nbr),
        .next_state (rule_next)
    );

    `BBS_ASSERT_IMP(a_gen_writes_spare_bank, win_ok, mem_waddr[bbs_pkg::MEM_AW-1] != bank_reg)
    `BBS_ASSERT_IMP(a_read_slot_free, state_reg == bbs_pkg::CTL_READ, !m_valid_reg)
    `BBS_ASSERT_IMP(a_bank_flip_at_end, bank_reg != $past(bank_reg), $past(state_reg) == bbs_pkg::CTL_GEN_DRAIN)

endmodule
